/* src/pcmt_pkg.sv */
// ----------------------------------------------------------------------------
// pcmt_pkg: shared definitions for the priority command multiplexer
// Widths, stream layouts, register indexes and the types passed between
// the top level and the arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmt_pkg;

    // Source count and width of one velocity component
    localparam int NUM_SOURCES     = 4;
    localparam int COMPONENT_WIDTH = 16;
    localparam int NUM_COMPONENTS  = 6;

    // Field widths
    localparam int SRC_W      = 2;
    localparam int PRI_W      = 8;
    localparam int AGE_W      = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMD_W      = NUM_COMPONENTS * COMPONENT_WIDTH;

    // An age stays at this value instead of wrapping
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((SRC_W + CMD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SRC_W + PRI_W + CMD_W + 7) / 8) * 8;

    // Reset values of the configuration registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(50);

    // Configuration register indexes: four timeouts, then four priorities
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TIMEOUT_SRC0  = 3'd0;
    localparam cfg_idx_t REG_PRIORITY_SRC0 = 3'd4;

    // Kind of input beat, carried on s_tuser
    typedef enum logic {
        ACT_MESSAGE = 1'b0,
        ACT_TICK    = 1'b1
    } action_t;

    // One velocity command; lin_x sits in the lowest bits
    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef struct packed {
        comp_t ang_z;
        comp_t ang_y;
        comp_t ang_x;
        comp_t lin_z;
        comp_t lin_y;
        comp_t lin_x;
    } cmd_t;

    // Arbiter request from one source
    typedef struct packed {
        logic             eligible;
        logic [PRI_W-1:0] prio;
    } cand_t;

    // Arbiter decision
    typedef struct packed {
        logic             found;
        logic [SRC_W-1:0] index;
    } grant_t;

endpackage

`default_nettype wire

/* src/pcmt_arbiter.sv */
// ----------------------------------------------------------------------------
// pcmt_arbiter: highest-priority pick among eligible sources
// Scans the sources in index order and keeps the first one with the largest
// priority, so a tie goes to the lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmt_arbiter
    import pcmt_pkg::*;
(
    input  cand_t  cand [NUM_SOURCES],
    output grant_t grant
);

    logic [PRI_W-1:0] best_prio;

    // Strictly larger priority replaces the current winner.
    always_comb begin
        grant     = '0;
        best_prio = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (cand[i].eligible && (!grant.found || cand[i].prio > best_prio)) begin
                grant.found = 1'b1;
                grant.index = SRC_W'(i);
                best_prio   = cand[i].prio;
            end
        end
    end

endmodule

`default_nettype wire

/* src/priority_command_mux_timeout.sv */
// ----------------------------------------------------------------------------
// priority_command_mux_timeout: velocity command multiplexer with timeouts
// Stores the latest command of each source, ages sources on tick beats and
// forwards, on every message, the command of the highest-priority source
// that is still within its timeout.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid/s_tready    tuser: action; tdata: source, command
//  m_        out        m_tvalid/m_tready    tdata: source, priority, command
//  cfg_      in         cfg_valid/cfg_ready  register index and write data
//
//  One beat is taken per cycle unless a message is held in the input register.
//  A beat is loaded into the input register; a message's result is then
//  loaded into the output register, from which m_ presents it.
//  Ticks give no result and pass even while the output is stalled; a message
//  waits in the input register while a result is not taken.
//  Reset restores the register defaults and forgets all sources.
//  cfg_ready is always high; writes take effect at the next edge.
//
`default_nettype none

module priority_command_mux_timeout
    import pcmt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // source_index, in_lin_x, in_lin_y, in_lin_z, in_ang_x, in_ang_y, in_ang_z
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic                  s_tuser,

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // selected_source, selected_priority, out_lin_x, out_lin_y, out_lin_z,
    // out_ang_x, out_ang_y, out_ang_z
    output      logic [M_TDATA_W-1:0]  m_tdata,

    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register
    logic             in_valid_reg;
    action_t          in_action_reg;
    logic [SRC_W-1:0] in_src_reg;
    cmd_t             in_cmd_reg;

    // Configuration
    logic [TIMEOUT_W-1:0] timeout_reg [NUM_SOURCES];
    logic [PRI_W-1:0]     prio_reg    [NUM_SOURCES];

    // Per-source state
    logic [AGE_W-1:0]       age_reg [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] rcv_reg;
    cmd_t                   cmd_store_reg [NUM_SOURCES];

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic                   out_free;
    logic                   advance;
    logic                   msg_valid;
    logic                   do_msg;
    logic                   do_tick;
    logic [NUM_SOURCES-1:0] hit;
    cand_t                  cand [NUM_SOURCES];
    grant_t                 grant;
    cmd_t                   sel_cmd;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Handshake: ticks never need the output, messages need a free slot.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (in_action_reg == ACT_TICK || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign msg_valid = (in_action_reg == ACT_MESSAGE) && (int'(in_src_reg) < NUM_SOURCES);
    assign do_msg    = advance && msg_valid;
    assign do_tick   = advance && (in_action_reg == ACT_TICK);

    // Input register load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_src_reg    <= s_tdata[SRC_W-1:0];
            in_cmd_reg    <= cmd_t'(s_tdata[SRC_W +: CMD_W]);
        end
    end

    // Configuration writes; the low index bits pick the source.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                timeout_reg[i] <= TIMEOUT_RESET;
                prio_reg[i]    <= PRI_W'(i);
            end
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                if (cfg_index[SRC_W-1:0] == SRC_W'(i)) begin
                    if (cfg_index < REG_PRIORITY_SRC0) begin
                        timeout_reg[i] <= cfg_data[TIMEOUT_W-1:0];
                    end else begin
                        prio_reg[i] <= cfg_data[PRI_W-1:0];
                    end
                end
            end
        end
    end

    // Candidates as seen after this message is stored: the sender counts
    // as received with age zero.
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            hit[i]           = msg_valid && (in_src_reg == SRC_W'(i));
            cand[i].eligible = (rcv_reg[i] || hit[i]) &&
                               ((hit[i] ? '0 : age_reg[i]) <= timeout_reg[i]);
            cand[i].prio     = prio_reg[i];
        end
    end

    pcmt_arbiter u_arbiter (
        .cand  (cand),
        .grant (grant)
    );

    // The sender's command comes straight from the input register.
    assign sel_cmd = (grant.index == in_src_reg) ? in_cmd_reg
                                                 : cmd_store_reg[grant.index];
    assign out_data_next = M_TDATA_W'({sel_cmd, prio_reg[grant.index], grant.index});

    // Per-source age, received flag and stored command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcv_reg <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                if (do_tick && age_reg[i] != AGE_MAX) begin
                    age_reg[i] <= age_reg[i] + AGE_W'(1);
                end else if (do_msg && hit[i]) begin
                    age_reg[i] <= '0;
                    rcv_reg[i] <= 1'b1;
                end
            end
        end
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (do_msg && hit[i]) begin
                cmd_store_reg[i] <= in_cmd_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= do_msg;
        end
        if (do_msg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* src/pcmt_checker.sv */
// ----------------------------------------------------------------------------
// pcmt_checker: port-level checks for the command multiplexer
// Watches the stream and configuration ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmt_checker
    import pcmt_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // A result waiting for the sink holds its beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An accepted message is followed by m_tvalid after the input and output registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_MESSAGE |=> ##1 m_tvalid)
        else $error("message beat produced no result");

    // The input side only stalls behind a result that is not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    // The configuration port never back-pressures.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // Leaving reset, no result is pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind priority_command_mux_timeout pcmt_checker u_pcmt_checker (.*);

`default_nettype wire
